// ===== hdl/bpli_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpli_pkg
// Shared constants and types of the beam pattern linear interpolator.
// ----------------------------------------------------------------------------
package bpli_pkg;

    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int RAD_W  = 18;
    localparam int ANG_W  = 16;
    localparam int AMP_W  = 16;
    localparam int IDX_W  = 6;
    localparam int CFG_W  = 7;
    localparam int DEG_W  = 17;
    localparam int PROD_W = 42;

    // 180/pi in Q16
    localparam logic signed [23:0] DEG_PER_RAD_Q16 = 24'sd3754936;
    localparam int DEG_SHIFT = 24;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic                    cmd;
        logic [IDX_W-1:0]        idx;
        logic signed [ANG_W-1:0] angle;
        logic [AMP_W-1:0]        amp;
        logic signed [DEG_W-1:0] deg;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== hdl/beam_pattern_linear_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beam_pattern_linear_interpolator
// Piecewise linear beam pattern lookup over a table of degree breakpoints.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready): cmd 0 loads one breakpoint (angle Q9.6,
//   amplitude Q4.12) at entry_index; cmd 1 queries with a Q3.14 radian angle.
//   Output channel (o_valid / i_ready): one transaction per query, none per
//   load, giving the interpolated Q4.12 amplitude and a clamp flag.
//   i_cfg_we writes point_count (clamped to 2..64); the user must write it
//   only while the block is idle, a rule the block leaves to the user.
// Structure and flow:
//   The front converts the angle through its s1 and s2 registers and feeds
//   a four-entry queue. The back walks the table one breakpoint at a time,
//   reading and comparing each through its single read port, then does
//   two entry reads, a multiply and a 36-step restoring divider, with the
//   multiply and divide skipped on a flat segment. It takes one query at a
//   time; a load is written to the table as it is popped from the queue.
// Reset and stall:
//   Synchronous reset clears the pipeline, queue and output; point_count
//   returns to 2. The table has no reset and must be loaded before use.
//   A stalled receiver holds the result; the back waits, the queue fills,
//   then o_ready drops.
// ----------------------------------------------------------------------------
module beam_pattern_linear_interpolator import bpli_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_cmd,
    input  logic [IDX_W-1:0]        i_entry_index,
    input  logic signed [ANG_W-1:0] i_entry_angle,
    input  logic [AMP_W-1:0]        i_entry_amplitude,
    input  logic signed [RAD_W-1:0] i_launch_angle,
    input  logic                    i_cfg_we,
    input  logic [CFG_W-1:0]        i_cfg_wdata,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [AMP_W-1:0]        o_amplitude,
    output logic                    o_saturated
);

    logic [CFG_W-1:0] r_point_count;
    logic             push;
    logic             pop;
    t_item            front_item;
    t_item            queue_item;
    t_q_status        q_status;

    // Hold the breakpoint count; software must write it only while idle, a rule left to the user.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= CFG_W'(2);
        end else if (i_cfg_we) begin
            r_point_count <= i_cfg_wdata;
        end
    end

    bpli_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_cmd             (i_cmd),
        .i_entry_index     (i_entry_index),
        .i_entry_angle     (i_entry_angle),
        .i_entry_amplitude (i_entry_amplitude),
        .i_launch_angle    (i_launch_angle),
        .i_q_status        (q_status),
        .o_push            (push),
        .o_item            (front_item)
    );

    bpli_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_item   (queue_item),
        .o_status (q_status)
    );

    bpli_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_point_count (r_point_count),
        .i_item        (queue_item),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_amplitude   (o_amplitude),
        .o_saturated   (o_saturated)
    );

endmodule

// ===== hdl/bpli_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpli_front
// Accepts transactions, converts the query angle to degrees and pushes items.
// ----------------------------------------------------------------------------
module bpli_front import bpli_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_cmd,
    input  logic [IDX_W-1:0]        i_entry_index,
    input  logic signed [ANG_W-1:0] i_entry_angle,
    input  logic [AMP_W-1:0]        i_entry_amplitude,
    input  logic signed [RAD_W-1:0] i_launch_angle,
    input  t_q_status               i_q_status,
    output logic                    o_push,
    output t_item                   o_item
);

    logic                     r_s1_valid;
    logic                     r_s1_cmd;
    logic [IDX_W-1:0]         r_s1_idx;
    logic signed [ANG_W-1:0]  r_s1_angle;
    logic [AMP_W-1:0]         r_s1_amp;
    logic signed [RAD_W-1:0]  r_s1_rad;

    logic                     r_s2_valid;
    logic                     r_s2_cmd;
    logic [IDX_W-1:0]         r_s2_idx;
    logic signed [ANG_W-1:0]  r_s2_angle;
    logic [AMP_W-1:0]         r_s2_amp;
    logic signed [PROD_W-1:0] r_s2_prod;

    logic                     s1_adv;
    logic signed [PROD_W-1:0] rounded;

    assign o_push  = r_s2_valid && !i_q_status.full;
    assign s1_adv  = r_s1_valid && (!r_s2_valid || o_push);
    assign o_ready = !r_s1_valid || s1_adv;

    // round half up, then floor shift
    assign rounded = r_s2_prod + (PROD_W'(1) <<< (DEG_SHIFT - 1));

    always_comb begin
        o_item.cmd   = r_s2_cmd;
        o_item.idx   = r_s2_idx;
        o_item.angle = r_s2_angle;
        o_item.amp   = r_s2_amp;
        o_item.deg   = DEG_W'(rounded >>> DEG_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s1_adv) begin
                r_s2_valid <= 1'b1;
            end else if (o_push) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1_cmd   <= i_cmd;
            r_s1_idx   <= i_entry_index;
            r_s1_angle <= i_entry_angle;
            r_s1_amp   <= i_entry_amplitude;
            r_s1_rad   <= i_launch_angle;
        end
        if (s1_adv) begin
            r_s2_cmd   <= r_s1_cmd;
            r_s2_idx   <= r_s1_idx;
            r_s2_angle <= r_s1_angle;
            r_s2_amp   <= r_s1_amp;
            r_s2_prod  <= PROD_W'(r_s1_rad * DEG_PER_RAD_Q16);
        end
    end

endmodule

// ===== hdl/bpli_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpli_queue
// Short item queue between the front and back parts.
// ----------------------------------------------------------------------------
module bpli_queue import bpli_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_item     i_item,
    input  logic      i_pop,
    output t_item     o_item,
    output t_q_status o_status
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [PW:0]   r_count;

    assign o_status.full  = (r_count == (PW+1)'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_item         = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

// ===== hdl/bpli_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpli_back
// Holds the breakpoint table, searches it, interpolates with a serial divider.
// ----------------------------------------------------------------------------
module bpli_back import bpli_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_point_count,
    input  t_item            i_item,
    input  t_q_status        i_q_status,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [AMP_W-1:0] o_amplitude,
    output logic             o_saturated
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRD   = 4'd1;
    localparam logic [3:0] S_SCMP  = 4'd2;
    localparam logic [3:0] S_LRD   = 4'd3;
    localparam logic [3:0] S_LLAT  = 4'd4;
    localparam logic [3:0] S_RLAT  = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_NORM  = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    localparam int NUM_W = 35;
    localparam int DVD_W = 36;
    localparam int DEN_W = 16;
    localparam int DC_W  = $clog2(DVD_W + 1);
    localparam int VAL_W = 38;

    logic [ANG_W+AMP_W-1:0] r_mem [MAX_POINTS];
    logic [ANG_W+AMP_W-1:0] r_rdata;
    logic [ADDR_W-1:0]      rd_addr;

    logic [3:0]              r_state;
    logic [CNT_W-1:0]        r_idx;
    logic [CNT_W-1:0]        r_n;
    logic [ADDR_W-1:0]       r_left;
    logic signed [DEG_W-1:0] r_deg;
    logic signed [ANG_W-1:0] r_al;
    logic signed [ANG_W-1:0] r_ar;
    logic [AMP_W-1:0]        r_ampl;
    logic [AMP_W-1:0]        r_ampr;
    logic                    r_flat;
    logic signed [NUM_W-1:0] r_num;
    logic                    r_neg;
    logic [DEN_W-1:0]        r_den;
    logic [DVD_W-1:0]        r_quo;
    logic [DEN_W:0]          r_rem;
    logic [DC_W-1:0]         r_dcnt;

    logic                    r_out_valid;
    logic [AMP_W-1:0]        r_out_amp;
    logic                    r_out_sat;

    logic                    mem_we;
    logic signed [ANG_W-1:0] rd_angle;
    logic [CNT_W-1:0]        n_clamped;
    logic [DEN_W+1:0]        trial;
    logic [NUM_W-1:0]        mag;
    logic signed [VAL_W-1:0] value;
    logic                    out_free;

    assign o_valid     = r_out_valid;
    assign o_amplitude = r_out_amp;
    assign o_saturated = r_out_sat;
    assign out_free    = !r_out_valid || i_ready;

    assign o_pop   = (r_state == S_IDLE) && !i_q_status.empty;
    assign mem_we  = o_pop && (i_item.cmd == CMD_LOAD) && (32'(i_item.idx) < MAX_POINTS);
    assign rd_angle = r_rdata[ANG_W+AMP_W-1:AMP_W];

    always_comb begin
        if (32'(i_point_count) < 2) begin
            n_clamped = CNT_W'(2);
        end else if (32'(i_point_count) > MAX_POINTS) begin
            n_clamped = CNT_W'(MAX_POINTS);
        end else begin
            n_clamped = CNT_W'(i_point_count);
        end
    end

    always_comb begin
        case (r_state)
            S_LRD:   rd_addr = r_left;
            S_LLAT:  rd_addr = r_left + 1'b1;
            default: rd_addr = r_idx[ADDR_W-1:0];
        endcase
    end

    assign trial = {r_rem, r_quo[DVD_W-1]};
    assign mag   = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);

    always_comb begin
        if (r_neg) begin
            value = VAL_W'(r_ampl) - VAL_W'(r_quo);
        end else begin
            value = VAL_W'(r_ampl) + VAL_W'(r_quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[ADDR_W'(i_item.idx)] <= {i_item.angle, i_item.amp};
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop && i_item.cmd == CMD_QUERY) begin
                        r_state <= S_SRD;
                    end
                end
                S_SRD: r_state <= S_SCMP;
                S_SCMP: begin
                    if (rd_angle >= r_deg || r_idx + 1'b1 == r_n) begin
                        r_state <= S_LRD;
                    end else begin
                        r_state <= S_SRD;
                    end
                end
                S_LRD:  r_state <= S_LLAT;
                S_LLAT: r_state <= S_RLAT;
                S_RLAT: begin
                    if (rd_angle <= r_al) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL:  r_state <= S_NORM;
                S_NORM: r_state <= S_DIV;
                S_DIV: begin
                    if (r_dcnt == DC_W'(1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_idx <= '0;
                r_n   <= n_clamped;
                r_deg <= i_item.deg;
            end
            S_SCMP: begin
                if (rd_angle >= r_deg) begin
                    r_left <= (r_idx == '0) ? '0 : ADDR_W'(r_idx - 1'b1);
                end else if (r_idx + 1'b1 == r_n) begin
                    r_left <= ADDR_W'(r_n - CNT_W'(2));
                end
                r_idx <= r_idx + 1'b1;
            end
            S_LLAT: begin
                r_al   <= rd_angle;
                r_ampl <= r_rdata[AMP_W-1:0];
            end
            S_RLAT: begin
                r_ar   <= rd_angle;
                r_ampr <= r_rdata[AMP_W-1:0];
                r_flat <= (rd_angle <= r_al);
            end
            S_MUL: begin
                r_num <= NUM_W'((DEG_W+1)'(r_deg) - (DEG_W+1)'(r_al))
                       * NUM_W'($signed({1'b0, r_ampr}) - $signed({1'b0, r_ampl}));
                r_den <= DEN_W'(r_ar - r_al);
            end
            S_NORM: begin
                r_neg  <= r_num[NUM_W-1];
                r_quo  <= DVD_W'(mag) + DVD_W'(r_den >> 1);
                r_rem  <= '0;
                r_dcnt <= DC_W'(DVD_W);
            end
            S_DIV: begin
                if (trial >= (DEN_W+2)'(r_den)) begin
                    r_rem <= (DEN_W+1)'(trial - (DEN_W+2)'(r_den));
                    r_quo <= {r_quo[DVD_W-2:0], 1'b1};
                end else begin
                    r_rem <= (DEN_W+1)'(trial);
                    r_quo <= {r_quo[DVD_W-2:0], 1'b0};
                end
                r_dcnt <= r_dcnt - 1'b1;
            end
            S_FIN: begin
                // hold the pending result until the output register frees up
                if (out_free) begin
                    if (r_flat) begin
                        r_out_amp <= r_ampl;
                        r_out_sat <= 1'b0;
                    end else if (value < 0) begin
                        r_out_amp <= '0;
                        r_out_sat <= 1'b1;
                    end else if (value > VAL_W'(65535)) begin
                        r_out_amp <= '1;
                        r_out_sat <= 1'b1;
                    end else begin
                        r_out_amp <= AMP_W'(value);
                        r_out_sat <= 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== hdl/bpli_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpli_checker
// Port-level checks on the interpolator output channel.
// ----------------------------------------------------------------------------
module bpli_checker import bpli_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_ready,
    input logic [AMP_W-1:0] o_amplitude,
    input logic             o_saturated
);

    // Drop any result after reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // A clamped result sits at one of the range limits.
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> (o_amplitude == '0 || o_amplitude == '1))
        else $error("saturated flag without limit value");

    // Hold a stalled result.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_amplitude) && $stable(o_saturated))
        else $error("stalled result changed");

endmodule

bind beam_pattern_linear_interpolator bpli_checker u_bpli_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_amplitude (o_amplitude),
    .o_saturated (o_saturated)
);
